### rtl/htfl_pkg.sv
package htfl_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int FUNC_W            = 2;
  localparam int HANDLE_W          = 9;
  localparam int OBJ_W             = 32;
  localparam int STATUS_W          = 2;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [OBJ_W-1:0]    obj_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FN_ALLOC  = 2'd0;
  localparam func_t FN_FREE   = 2'd1;
  localparam func_t FN_LOOKUP = 2'd2;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_DEAD = 2'd2;

endpackage

### rtl/htfl_if.sv
interface htfl_req_if;
  import htfl_pkg::*;

  logic    valid;
  logic    ready;
  func_t   func;
  handle_t handle;
  obj_t    object;

  modport source (output valid, func, handle, object, input ready);
  modport sink (input valid, func, handle, object, output ready);
  modport monitor (input valid, ready, func, handle, object);
endinterface

interface htfl_rsp_if;
  import htfl_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  handle_t handle_out;
  obj_t    object_out;

  modport source (output valid, status, handle_out, object_out, input ready);
  modport sink (input valid, status, handle_out, object_out, output ready);
  modport monitor (input valid, ready, status, handle_out, object_out);
endinterface

### rtl/handle_table_free_list_top.sv
// Handle table: allocate stores an object and returns handle index+1, free
// pushes a live entry onto a free chain kept in the table, look-up returns
// the object of a live handle. An item is handled in S_IDLE, which reads the
// table entry it names (the free head for an allocate) as the item is taken,
// then in S_EXEC, which updates that entry and the head and loads the result
// register; the registered read of the single table memory sets this. A
// result waits in its register while the next item is taken; that item's update holds until the
// register drains. A high-water mark tells never-used entries apart, so the
// table needs no clearing pass after reset and accepts an item at once.
module handle_table_free_list_top #(
  parameter int TABLE_ENTRIES = htfl_pkg::TABLE_ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  htfl_req_if.sink   in_req,
  htfl_rsp_if.source out_rsp
);
  import htfl_pkg::*;

  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int HDW = $clog2(TABLE_ENTRIES + 1);
  localparam int DW  = 1 + OBJ_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t         state_r, state_nxt;
  func_t          func_r;
  handle_t        handle_r;
  obj_t           obj_r;
  logic [IW-1:0]  addr_r;
  logic [HDW-1:0] head_r, head_nxt;
  logic [HDW-1:0] hwm_r, hwm_nxt;
  logic           out_valid_r, out_valid_nxt;
  status_t        status_r, status_nxt;
  handle_t        hout_r, hout_nxt;
  obj_t           oout_r, oout_nxt;

  logic           in_accept;
  logic [IW-1:0]  rd_addr;
  logic [DW-1:0]  rd_data;
  logic           wr_en;
  logic [DW-1:0]  wr_data;
  logic           out_free;
  logic           h_in_range;
  logic           h_live;
  logic           head_full;
  logic           head_never;
  obj_t           link;
  logic [HDW-1:0] link_clamped;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_accept    = in_req.valid && in_req.ready;
  assign rd_addr      = (in_req.func == FN_ALLOC) ? head_r[IW-1:0]
                                                  : IW'(in_req.handle) - 1'b1;

  htfl_table #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW),
    .DW    (DW)
  ) u_table (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_data (wr_data)
  );

  assign out_free     = !out_valid_r || out_rsp.ready;
  assign h_in_range   = (handle_r != '0) && (32'(handle_r) <= 32'(TABLE_ENTRIES));
  assign h_live       = h_in_range && (HDW'(addr_r) < hwm_r) && rd_data[DW-1];
  assign head_full    = (head_r == HDW'(TABLE_ENTRIES));
  assign head_never   = (head_r >= hwm_r);
  assign link         = rd_data[OBJ_W-1:0];
  assign link_clamped = (link > 32'(TABLE_ENTRIES)) ? HDW'(TABLE_ENTRIES)
                                                    : link[HDW-1:0];

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    hwm_nxt       = hwm_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    status_nxt    = status_r;
    hout_nxt      = hout_r;
    oout_nxt      = oout_r;
    wr_en         = 1'b0;
    wr_data       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_DEAD;
          hout_nxt      = handle_r;
          oout_nxt      = '0;
          case (func_r)
            FN_ALLOC: begin
              if (head_full || (!head_never && rd_data[DW-1])) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_data    = {1'b1, obj_r};
                status_nxt = ST_OK;
                hout_nxt   = HANDLE_W'(head_r) + 1'b1;
                if (head_never) begin
                  head_nxt = head_r + 1'b1;
                  hwm_nxt  = head_r + 1'b1;
                end else begin
                  head_nxt = link_clamped;
                end
              end
            end
            FN_FREE: begin
              if (h_live) begin
                wr_en      = 1'b1;
                wr_data    = {1'b0, OBJ_W'(head_r)};
                head_nxt   = HDW'(addr_r);
                status_nxt = ST_OK;
              end
            end
            FN_LOOKUP: begin
              if (h_live) begin
                status_nxt = ST_OK;
                oout_nxt   = rd_data[OBJ_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      hwm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      hwm_r       <= hwm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r   <= in_req.func;
      handle_r <= in_req.handle;
      obj_r    <= in_req.object;
      addr_r   <= rd_addr;
    end
    status_r <= status_nxt;
    hout_r   <= hout_nxt;
    oout_r   <= oout_nxt;
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = status_r;
  assign out_rsp.handle_out = hout_r;
  assign out_rsp.object_out = oout_r;

endmodule

### rtl/htfl_table.sv
module htfl_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 33
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/htfl_checker.sv
module htfl_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input htfl_pkg::status_t       out_status,
  input htfl_pkg::handle_t       out_handle_out,
  input htfl_pkg::obj_t          out_object_out
);
  import htfl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_handle_out) && $stable(out_object_out))
    else $error("result beat changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is at work");

  a_obj_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_object_out == '0)
    else $error("object returned with a failing status");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind handle_table_free_list_top htfl_checker u_htfl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_status     (out_rsp.status),
  .out_handle_out (out_rsp.handle_out),
  .out_object_out (out_rsp.object_out)
);

### verif/tb_handle_table_free_list_top.sv
`timescale 1ns / 1ps

module tb_handle_table_free_list_top;
  import htfl_pkg::*;

  class handle_ledger;

    typedef enum logic [1:0] {ENT_NEVER, ENT_FREE, ENT_LIVE} entry_kind_t;

    typedef struct {
      status_t status;
      handle_t handle_out;
      obj_t    object_out;
    } rsp_beat_t;

    int unsigned  entries;
    entry_kind_t  kind[];
    logic [31:0]  link_or_obj[];
    int unsigned  free_head;
    int unsigned  live_count;
    rsp_beat_t    pending_rsp[$];
    int unsigned  errors;

    function new(int unsigned n);
      entries = n;
      kind = new[n];
      link_or_obj = new[n];
      foreach (kind[i]) begin
        kind[i] = ENT_NEVER;
        link_or_obj[i] = '0;
      end
      free_head = 0;
      live_count = 0;
      errors = 0;
    endfunction

    function bit is_live(handle_t h);
      if (h == 0 || h > entries) return 1'b0;
      return kind[h - 1] == ENT_LIVE;
    endfunction

    function handle_t pick_live();
      int unsigned start;
      int unsigned idx;
      if (live_count == 0) return '0;
      start = $urandom_range(entries - 1);
      for (int unsigned k = 0; k < entries; k++) begin
        idx = (start + k) % entries;
        if (kind[idx] == ENT_LIVE) return handle_t'(idx + 1);
      end
      return '0;
    endfunction

    function void take_request(func_t f, handle_t h, obj_t o);
      rsp_beat_t   r;
      int unsigned i;
      r.status = ST_DEAD;
      r.handle_out = h;
      r.object_out = '0;
      case (f)
        FN_ALLOC: begin
          i = free_head;
          if (i >= entries || kind[i] == ENT_LIVE) begin
            r.status = ST_FULL;
          end else begin
            if (kind[i] == ENT_NEVER) free_head = i + 1;
            else free_head = (link_or_obj[i] > entries) ? entries : link_or_obj[i];
            kind[i] = ENT_LIVE;
            link_or_obj[i] = o;
            r.status = ST_OK;
            r.handle_out = handle_t'(i + 1);
            live_count++;
          end
        end
        FN_FREE: begin
          if (is_live(h)) begin
            kind[h - 1] = ENT_FREE;
            link_or_obj[h - 1] = free_head;
            free_head = h - 1;
            r.status = ST_OK;
            live_count--;
          end
        end
        FN_LOOKUP: begin
          if (is_live(h)) begin
            r.status = ST_OK;
            r.object_out = link_or_obj[h - 1];
          end
        end
        default: ;
      endcase
      pending_rsp.push_back(r);
    endfunction

    function void check_response(status_t s, handle_t h, obj_t o);
      rsp_beat_t e;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response beat: expected none, actual status %0d",
                 $time, s, " handle %0d object %h", h, o);
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      if (s !== e.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, s);
        errors++;
      end
      if (h !== e.handle_out) begin
        $display("%0t: handle_out mismatch: expected %0d, actual %0d", $time, e.handle_out, h);
        errors++;
      end
      if (o !== e.object_out) begin
        $display("%0t: object_out mismatch: expected %h, actual %h", $time, e.object_out, o);
        errors++;
      end
    endfunction
  endclass

  localparam int ENTRIES     = TABLE_ENTRIES_DEF;
  localparam int RAND_ITEMS  = 1600;

  logic clk;
  logic rst_n;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  htfl_req_if req_bus ();
  htfl_rsp_if rsp_bus ();

  handle_ledger ledger;

  handle_table_free_list_top #(.TABLE_ENTRIES(ENTRIES)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_rsp (rsp_bus)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.func = FN_ALLOC;
    req_bus.handle = '0;
    req_bus.object = '0;
    rsp_bus.ready = 1'b0;
    tx_idle_pct = 12;
    rx_idle_pct = 64;
    ledger = new(ENTRIES);
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (req_bus.valid && req_bus.ready)
        ledger.take_request(req_bus.func, req_bus.handle, req_bus.object);
      if (rsp_bus.valid && rsp_bus.ready)
        ledger.check_response(rsp_bus.status, rsp_bus.handle_out, rsp_bus.object_out);
    end
  end

  task automatic send_request(func_t f, handle_t h, obj_t o);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.func <= f;
    req_bus.handle <= h;
    req_bus.object <= o;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
  endtask

  function automatic obj_t rand_object();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic handle_t rand_target();
    handle_t h;
    if ($urandom_range(99) < 80) begin
      h = ledger.pick_live();
      if (h != 0) return h;
    end
    return handle_t'($urandom_range(511));
  endfunction

  task automatic run_directed();
    send_request(FN_LOOKUP, 9'd0, 32'h0);
    send_request(FN_FREE, 9'd0, 32'hFFFF_FFFF);
    send_request(FN_LOOKUP, 9'd511, 32'h0);
    send_request(FN_FREE, 9'd256, 32'h0);
    send_request(func_t'(3), 9'd511, 32'hFFFF_FFFF);
    send_request(FN_ALLOC, 9'd0, 32'h0000_0000);
    send_request(FN_ALLOC, 9'd511, 32'hFFFF_FFFF);
    send_request(FN_ALLOC, 9'd0, 32'hA5A5_5A5A);
    send_request(FN_LOOKUP, 9'd1, 32'h0);
    send_request(FN_LOOKUP, 9'd2, 32'h0);
    send_request(FN_FREE, 9'd1, 32'h0);
    send_request(FN_FREE, 9'd1, 32'h0);
    send_request(FN_LOOKUP, 9'd1, 32'h0);
    send_request(FN_FREE, 9'd3, 32'h0);
    send_request(FN_ALLOC, 9'd0, 32'h1234_5678);
    send_request(FN_ALLOC, 9'd0, 32'h8000_0001);
    send_request(FN_ALLOC, 9'd0, 32'hFFFF_0000);
    send_request(FN_LOOKUP, 9'd3, 32'h0);
    send_request(FN_LOOKUP, 9'd257, 32'h0);
    send_request(func_t'(3), 9'd0, 32'h0);
  endtask

  task automatic run_random();
    bit          filling;
    int unsigned full_hold;
    int unsigned roll;
    func_t       f;
    filling = 1'b1;
    full_hold = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        tx_idle_pct = 64;
        rx_idle_pct = 12;
      end else if (n == 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (filling && ledger.free_head >= ENTRIES && ++full_hold > 20) begin
        filling = 1'b0;
        full_hold = 0;
      end else if (!filling && ledger.live_count < 4) begin
        filling = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 3) f = func_t'(3);
      else if (filling) f = (roll < 70) ? FN_ALLOC : (roll < 85) ? FN_FREE : FN_LOOKUP;
      else f = (roll < 20) ? FN_ALLOC : (roll < 75) ? FN_FREE : FN_LOOKUP;
      send_request(f, (f == FN_ALLOC) ? handle_t'($urandom_range(511)) : rand_target(),
                   rand_object());
    end
    req_bus.valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    run_random();
    while (ledger.pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (ledger.errors == 0)
      $display("handle_table_free_list_top regression: pass");
    else
      $display("handle_table_free_list_top regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("handle_table_free_list_top regression: fail");
    $finish;
  end

endmodule
